FILE: rtl/prqs_pkg.sv
// Shared types and constants for the priority ready-queue scheduler.
package prqs_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int ID_W        = 16;
    localparam int PRI_W       = 6;
    localparam int SLICE_W     = 8;
    localparam int TICK_W      = 32;
    localparam int ADDR_W      = 3;
    localparam int DATA_W      = 32;

    localparam logic [ID_W-1:0]    INITIAL_ID       = 16'd1;
    localparam logic [PRI_W-1:0]   INITIAL_PRIORITY = 6'd31;
    localparam logic [ID_W-1:0]    FIRST_FREE_ID    = 16'd3;
    localparam logic [SLICE_W-1:0] DEFAULT_SLICE    = 8'd4;

    localparam logic [2:0] KIND_TICK    = 3'd0;
    localparam logic [2:0] KIND_CREATE  = 3'd1;
    localparam logic [2:0] KIND_UNBLOCK = 3'd2;
    localparam logic [2:0] KIND_YIELD   = 3'd3;
    localparam logic [2:0] KIND_BLOCK   = 3'd4;
    localparam logic [2:0] KIND_SETPRI  = 3'd5;

    localparam logic REG_TIME_SLICE = 1'b0;

    typedef struct packed {
        logic [2:0]       kind;
        logic [ID_W-1:0]  thread_id;
        logic [PRI_W-1:0] priority_req;
    } item_t;

    typedef struct packed {
        logic [ID_W-1:0]   running_id;
        logic [PRI_W-1:0]  running_priority;
        logic              running_is_idle;
        logic              switched;
        logic [ID_W-1:0]   new_id;
        logic              status;
        logic [TICK_W-1:0] idle_total;
        logic [TICK_W-1:0] busy_ticks;
    } result_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD,
        OP_TICK,
        OP_ENQ_REQ,
        OP_ENQ_CUR,
        OP_SETPRIO,
        OP_POP
    } op_t;

    typedef struct packed {
        op_t  op;
        logic set_err;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic [2:0] kind;
        logic       full;
        logic       idle;
        logic       preempt;
        logic       slice_expired;
    } stat_t;

endpackage

FILE: rtl/prqs_regs.sv
// Configuration register file: time slice.
module prqs_regs (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [prqs_pkg::ADDR_W-1:0]  paddr,
    input  logic [prqs_pkg::DATA_W-1:0]  pwdata,
    output logic [prqs_pkg::DATA_W-1:0]  prdata,
    output logic                         pready,
    output logic [prqs_pkg::SLICE_W-1:0] slice_limit
);

    logic [prqs_pkg::SLICE_W-1:0] slice_limit_reg;
    logic                         sel_slice;

    assign sel_slice   = (paddr[2] == prqs_pkg::REG_TIME_SLICE);
    assign pready      = 1'b1;
    assign slice_limit = slice_limit_reg;
    assign prdata      = sel_slice ? prqs_pkg::DATA_W'(slice_limit_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slice_limit_reg <= prqs_pkg::DEFAULT_SLICE;
        end
        else if (psel && penable && pwrite && pready && sel_slice)
        begin
            slice_limit_reg <= pwdata[prqs_pkg::SLICE_W-1:0];
        end
    end

endmodule

FILE: rtl/prqs_ctrl.sv
// Event sequencer: issues at most one queue or state operation per cycle.
module prqs_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  prqs_pkg::stat_t stat,
    output prqs_pkg::cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_CHK_SLICE,
        S_CHK_PRE,
        S_YIELD,
        S_POP,
        S_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        state_next  = state_reg;
        cmd.op      = prqs_pkg::OP_NONE;
        cmd.set_err = 1'b0;
        cmd.emit    = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.op     = prqs_pkg::OP_LOAD;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_DONE;
                case (stat.kind)
                    prqs_pkg::KIND_TICK:
                    begin
                        cmd.op     = prqs_pkg::OP_TICK;
                        state_next = S_CHK_SLICE;
                    end
                    prqs_pkg::KIND_CREATE:
                    begin
                        if (stat.full)
                        begin
                            cmd.set_err = 1'b1;
                        end
                        else
                        begin
                            cmd.op     = prqs_pkg::OP_ENQ_REQ;
                            state_next = S_CHK_PRE;
                        end
                    end
                    prqs_pkg::KIND_UNBLOCK:
                    begin
                        if (stat.full)
                        begin
                            cmd.set_err = 1'b1;
                        end
                        else
                        begin
                            cmd.op = prqs_pkg::OP_ENQ_REQ;
                        end
                    end
                    prqs_pkg::KIND_YIELD:
                    begin
                        state_next = S_YIELD;
                    end
                    prqs_pkg::KIND_BLOCK:
                    begin
                        cmd.op = prqs_pkg::OP_POP;
                    end
                    prqs_pkg::KIND_SETPRI:
                    begin
                        cmd.op     = prqs_pkg::OP_SETPRIO;
                        state_next = S_CHK_PRE;
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_CHK_SLICE:
            begin
                state_next = stat.slice_expired ? S_YIELD : S_DONE;
            end
            S_CHK_PRE:
            begin
                state_next = stat.preempt ? S_YIELD : S_DONE;
            end
            S_YIELD:
            begin
                if (!stat.idle)
                begin
                    if (stat.full)
                    begin
                        cmd.set_err = 1'b1;
                    end
                    else
                    begin
                        cmd.op = prqs_pkg::OP_ENQ_CUR;
                    end
                end
                state_next = S_POP;
            end
            S_POP:
            begin
                cmd.op     = prqs_pkg::OP_POP;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                cmd.emit   = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: rtl/prqs_dpath.sv
// Datapath: sorted ready queue, running thread, counters and result word.
module prqs_dpath (
    input  logic                         clk,
    input  logic                         rst_n,
    input  prqs_pkg::item_t              item,
    input  logic [prqs_pkg::SLICE_W-1:0] slice_limit,
    input  prqs_pkg::cmd_t               cmd,
    output prqs_pkg::stat_t              stat,
    output logic                         done,
    output prqs_pkg::result_t            result
);

    localparam int DEPTH = prqs_pkg::QUEUE_DEPTH;
    localparam int CW    = prqs_pkg::CNT_W;
    localparam int IW    = prqs_pkg::ID_W;
    localparam int PW    = prqs_pkg::PRI_W;
    localparam int TW    = prqs_pkg::TICK_W;
    localparam int SW    = prqs_pkg::SLICE_W;

    logic [IW-1:0] q_id_reg   [DEPTH];
    logic [IW-1:0] q_id_next  [DEPTH];
    logic [PW-1:0] q_pri_reg  [DEPTH];
    logic [PW-1:0] q_pri_next [DEPTH];
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;

    logic [IW-1:0] cur_id_reg;
    logic [IW-1:0] cur_id_next;
    logic [PW-1:0] cur_pri_reg;
    logic [PW-1:0] cur_pri_next;
    logic          cur_idle_reg;
    logic          cur_idle_next;
    logic [SW-1:0] slice_reg;
    logic [SW-1:0] slice_next;
    logic [IW-1:0] next_id_reg;
    logic [IW-1:0] next_id_next;
    logic [TW-1:0] idle_cnt_reg;
    logic [TW-1:0] idle_cnt_next;
    logic [TW-1:0] busy_cnt_reg;
    logic [TW-1:0] busy_cnt_next;

    prqs_pkg::item_t   item_reg;
    logic [IW-1:0]     was_id_reg;
    logic              was_idle_reg;
    logic              err_reg;
    logic [IW-1:0]     assigned_reg;
    logic              done_reg;
    prqs_pkg::result_t result_reg;
    prqs_pkg::result_t result_next;

    logic [IW-1:0]    ins_id;
    logic [PW-1:0]    ins_pri;
    logic [DEPTH-1:0] ge;
    logic             is_create;
    logic [PW-1:0]    cur_eff;

    assign is_create = (item_reg.kind == prqs_pkg::KIND_CREATE);
    assign cur_eff   = cur_idle_reg ? '0 : cur_pri_reg;

    assign stat.kind          = item_reg.kind;
    assign stat.full          = (count_reg == CW'(DEPTH));
    assign stat.idle          = cur_idle_reg;
    assign stat.preempt       = (count_reg != '0) && (cur_eff < q_pri_reg[0]);
    assign stat.slice_expired = (slice_reg >= slice_limit);

    assign done   = done_reg;
    assign result = result_reg;

    always_comb
    begin
        if (cmd.op == prqs_pkg::OP_ENQ_CUR)
        begin
            ins_id  = cur_id_reg;
            ins_pri = cur_pri_reg;
        end
        else
        begin
            ins_id  = is_create ? next_id_reg : item_reg.thread_id;
            ins_pri = item_reg.priority_req;
        end
    end

    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            ge[i] = (CW'(i) < count_reg) && (q_pri_reg[i] >= ins_pri);
        end
    end

    always_comb
    begin
        q_id_next     = q_id_reg;
        q_pri_next    = q_pri_reg;
        count_next    = count_reg;
        cur_id_next   = cur_id_reg;
        cur_pri_next  = cur_pri_reg;
        cur_idle_next = cur_idle_reg;
        slice_next    = slice_reg;
        next_id_next  = next_id_reg;
        idle_cnt_next = idle_cnt_reg;
        busy_cnt_next = busy_cnt_reg;
        case (cmd.op)
            prqs_pkg::OP_TICK:
            begin
                if (cur_idle_reg)
                begin
                    idle_cnt_next = idle_cnt_reg + TW'(1);
                end
                else
                begin
                    busy_cnt_next = busy_cnt_reg + TW'(1);
                end
                slice_next = slice_reg + SW'(1);
            end
            prqs_pkg::OP_ENQ_REQ, prqs_pkg::OP_ENQ_CUR:
            begin
                // insert behind all entries of equal or higher priority
                if (!ge[0])
                begin
                    q_id_next[0]  = ins_id;
                    q_pri_next[0] = ins_pri;
                end
                for (int i = 1; i < DEPTH; i++)
                begin
                    if (!ge[i])
                    begin
                        q_id_next[i]  = ge[i-1] ? ins_id  : q_id_reg[i-1];
                        q_pri_next[i] = ge[i-1] ? ins_pri : q_pri_reg[i-1];
                    end
                end
                count_next = count_reg + CW'(1);
                if (cmd.op == prqs_pkg::OP_ENQ_REQ && is_create)
                begin
                    next_id_next = next_id_reg + IW'(1);
                end
            end
            prqs_pkg::OP_SETPRIO:
            begin
                if (!cur_idle_reg)
                begin
                    cur_pri_next = item_reg.priority_req;
                end
            end
            prqs_pkg::OP_POP:
            begin
                slice_next = '0;
                if (count_reg == '0)
                begin
                    cur_idle_next = 1'b1;
                    cur_id_next   = '0;
                    cur_pri_next  = '0;
                end
                else
                begin
                    cur_idle_next = 1'b0;
                    cur_id_next   = q_id_reg[0];
                    cur_pri_next  = q_pri_reg[0];
                    for (int i = 0; i < DEPTH - 1; i++)
                    begin
                        q_id_next[i]  = q_id_reg[i+1];
                        q_pri_next[i] = q_pri_reg[i+1];
                    end
                    count_next = count_reg - CW'(1);
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        result_next.running_id       = cur_idle_reg ? '0 : cur_id_reg;
        result_next.running_priority = cur_idle_reg ? '0 : cur_pri_reg;
        result_next.running_is_idle  = cur_idle_reg;
        result_next.switched         = (was_idle_reg != cur_idle_reg) ||
                                       (was_id_reg != cur_id_reg);
        result_next.new_id           = assigned_reg;
        result_next.status           = err_reg;
        result_next.idle_total       = idle_cnt_reg;
        result_next.busy_ticks       = busy_cnt_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            cur_id_reg   <= prqs_pkg::INITIAL_ID;
            cur_pri_reg  <= prqs_pkg::INITIAL_PRIORITY;
            cur_idle_reg <= 1'b0;
            slice_reg    <= '0;
            next_id_reg  <= prqs_pkg::FIRST_FREE_ID;
            idle_cnt_reg <= '0;
            busy_cnt_reg <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            count_reg    <= count_next;
            cur_id_reg   <= cur_id_next;
            cur_pri_reg  <= cur_pri_next;
            cur_idle_reg <= cur_idle_next;
            slice_reg    <= slice_next;
            next_id_reg  <= next_id_next;
            idle_cnt_reg <= idle_cnt_next;
            busy_cnt_reg <= busy_cnt_next;
            done_reg     <= cmd.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        q_id_reg  <= q_id_next;
        q_pri_reg <= q_pri_next;
        if (cmd.op == prqs_pkg::OP_LOAD)
        begin
            item_reg     <= item;
            was_id_reg   <= cur_id_reg;
            was_idle_reg <= cur_idle_reg;
            err_reg      <= 1'b0;
            assigned_reg <= '0;
        end
        else
        begin
            if (cmd.set_err)
            begin
                err_reg <= 1'b1;
            end
            if (cmd.op == prqs_pkg::OP_ENQ_REQ && is_create)
            begin
                assigned_reg <= next_id_reg;
            end
        end
        if (cmd.emit)
        begin
            result_reg <= result_next;
        end
    end

endmodule

FILE: rtl/priority_ready_queue_scheduler.sv
// Top level of the priority ready-queue thread scheduler.
// One scheduling event is taken when start is high and busy is low; its word
// appears on result for exactly one cycle with done high, in the first cycle
// in which busy is low, and the receiver must take it then. An event holds the
// block from accept to the next possible accept. Block/exit and unblock do
// one queue operation, unused kinds none, a create on a full queue only
// flags an error; a tick, a create or a set-priority adds a slice or
// preemption check; yield and any check that fires requeue a running
// thread and pop the next. The sequencer does at most one queue operation
// (ordered insert or pop of the 16-entry shift queue) per cycle.
module priority_ready_queue_scheduler (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  prqs_pkg::item_t             item,
    output logic                        done,
    output prqs_pkg::result_t           result,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [prqs_pkg::ADDR_W-1:0] paddr,
    input  logic [prqs_pkg::DATA_W-1:0] pwdata,
    output logic [prqs_pkg::DATA_W-1:0] prdata,
    output logic                        pready
);

    prqs_pkg::cmd_t               cmd;
    prqs_pkg::stat_t              stat;
    logic [prqs_pkg::SLICE_W-1:0] slice_limit;

    prqs_regs u_regs (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .slice_limit (slice_limit)
    );

    prqs_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .cmd   (cmd)
    );

    prqs_dpath u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .item        (item),
        .slice_limit (slice_limit),
        .cmd         (cmd),
        .stat        (stat),
        .done        (done),
        .result      (result)
    );

    a_done_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result word while busy");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted word did not make block busy");

    a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.running_is_idle) |->
            (result.running_id == '0 && result.running_priority == '0))
        else $error("idle result with nonzero id or priority");

endmodule
